// ----- hdl/segment_tree_point_set_range_sum_macros.svh -----
// Assertion macros shared by the segment tree sum block.
`ifndef SEGMENT_TREE_POINT_SET_RANGE_SUM_MACROS_SVH
`define SEGMENT_TREE_POINT_SET_RANGE_SUM_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define STS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sts_pkg.sv -----
// Package with types and constants of the segment tree sum block.
package sts_pkg;

    localparam int unsigned LEAF_COUNT_DEFAULT = 1024;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned SUM_W = 64;

    typedef enum logic {
        ACT_SET   = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic                 is_query;
        logic                 is_empty;
        logic [INDEX_W:0]     lo;
        logic [INDEX_W:0]     hi;
        logic [SUM_W-1:0]     value;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SET_LEAF,
        ST_UP_READ_L,
        ST_UP_READ_R,
        ST_UP_WAIT,
        ST_UP_WRITE,
        ST_Q_STEP,
        ST_Q_READ,
        ST_Q_ACC,
        ST_Q_DONE
    } state_t;

endpackage

// ----- hdl/segment_tree_point_set_range_sum.sv -----
// Top level of the segment tree sum block: front end, queue and tree walker.
//
// A user issues one command per transfer with start while busy is low. A set
// (action 0) writes a sign-extended leaf and rebuilds the path to the root; it
// returns nothing. A query (action 1) returns the 64-bit wrapping sum of leaves
// first_index..last_index on range_sum for exactly one cycle, marked by
// result_valid; the receiver cannot stall, so results are simply presented.
// After reset the tree memory is cleared, one entry per cycle, for all
// 2*LEAF_COUNT entries while busy is high. The tree lives in one single-port
// memory, and its port sets the pace: a set writes the leaf, then for each
// level reads the left child, reads the right child, waits for the data and
// writes the parent sum; a query, level by level, reads and accumulates the
// odd edge nodes, then presents the result. A two-entry queue lets a command
// be taken while the previous one is still being walked.
module segment_tree_point_set_range_sum #(
    parameter int unsigned LEAF_COUNT = sts_pkg::LEAF_COUNT_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               action,
    input  logic [sts_pkg::INDEX_W-1:0]        first_index,
    input  logic [sts_pkg::INDEX_W-1:0]        last_index,
    input  logic signed [sts_pkg::VALUE_W-1:0] set_value,
    output logic                               result_valid,
    output logic signed [sts_pkg::SUM_W-1:0]   range_sum
);

`include "segment_tree_point_set_range_sum_macros.svh"

    logic          take, pop, full, not_empty, clearing, idle, done;
    sts_pkg::cmd_t head;
    logic [sts_pkg::SUM_W-1:0] sum;

    assign busy = full || clearing;
    assign take = start && !busy;

    sts_front #(.LEAF_COUNT(LEAF_COUNT)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .action      (action),
        .first_index (first_index),
        .last_index  (last_index),
        .set_value   (set_value),
        .pop         (pop),
        .full        (full),
        .not_empty   (not_empty),
        .head        (head)
    );

    sts_back #(.LEAF_COUNT(LEAF_COUNT)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (not_empty),
        .cmd       (head),
        .pop       (pop),
        .clearing  (clearing),
        .idle      (idle),
        .done      (done),
        .range_sum (sum)
    );

    assign result_valid = done;
    assign range_sum    = sum;

    `STS_ASSERT_IMPL(a_pop_needs_cmd, pop, not_empty && idle, "pop with empty queue")
    `STS_ASSERT_IMPL(a_no_take_clear, clearing, !take, "command taken during clear")
    `STS_ASSERT_NEXT(a_done_pulse, result_valid, !result_valid, "result held two cycles")

endmodule

// ----- hdl/sts_ram.sv -----
// Generic single-port RAM with registered read.
module sts_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/sts_front.sv -----
// Front end: classifies items and queues them as commands.
module sts_front #(
    parameter int unsigned LEAF_COUNT = sts_pkg::LEAF_COUNT_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  logic                       action,
    input  logic [sts_pkg::INDEX_W-1:0] first_index,
    input  logic [sts_pkg::INDEX_W-1:0] last_index,
    input  logic signed [sts_pkg::VALUE_W-1:0] set_value,
    input  logic                       pop,
    output logic                       full,
    output logic                       not_empty,
    output sts_pkg::cmd_t              head
);

    localparam int unsigned IW = sts_pkg::INDEX_W;

    sts_pkg::cmd_t q_reg [2];
    sts_pkg::cmd_t cmd;
    logic          wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [IW:0]   lo_x, hi_c;
    logic          push;

    always_comb
    begin
        lo_x = {1'b0, first_index};
        hi_c = {1'b0, last_index};
        if (hi_c >= (IW+1)'(LEAF_COUNT))
        begin
            hi_c = (IW+1)'(LEAF_COUNT - 1);
        end
        cmd.is_query = (action == sts_pkg::ACT_QUERY);
        cmd.lo       = lo_x;
        cmd.hi       = hi_c;
        cmd.value    = {{(sts_pkg::SUM_W-sts_pkg::VALUE_W){set_value[sts_pkg::VALUE_W-1]}},
                        set_value};
        if (cmd.is_query)
        begin
            cmd.is_empty = (lo_x >= (IW+1)'(LEAF_COUNT)) || (lo_x > hi_c);
        end
        else
        begin
            cmd.is_empty = (lo_x >= (IW+1)'(LEAF_COUNT));
        end
    end

    assign push      = take;
    assign full      = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head      = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- hdl/sts_back.sv -----
// Back end: clears the tree, walks it for sets and queries.
module sts_back #(
    parameter int unsigned LEAF_COUNT = sts_pkg::LEAF_COUNT_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    input  sts_pkg::cmd_t             cmd,
    output logic                      pop,
    output logic                      clearing,
    output logic                      idle,
    output logic                      done,
    output logic [sts_pkg::SUM_W-1:0] range_sum
);

    localparam int unsigned DEPTH = 2 * LEAF_COUNT;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned PW    = AW + 1;
    localparam int unsigned SW    = sts_pkg::SUM_W;

    sts_pkg::state_t state_reg, state_next;
    // The walk pointers carry one extra bit: the right bound starts one past the last leaf.
    logic [PW-1:0]   p_reg, p_next, r_reg, r_next;
    logic [AW-1:0]   cp_reg, cp_next;
    logic [SW-1:0]   acc_reg, acc_next, left_reg, left_next;
    logic [SW-1:0]   sum_reg, sum_next;
    logic            pend_reg, pend_next, use_r_reg, use_r_next;
    logic            done_reg, done_next;
    logic            we;
    logic [AW-1:0]   addr;
    logic [SW-1:0]   wdata, rdata;

    sts_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    // Next-state and datapath.
    always_comb
    begin
        state_next = state_reg;
        p_next     = p_reg;
        r_next     = r_reg;
        cp_next    = cp_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        sum_next   = sum_reg;
        pend_next  = pend_reg;
        use_r_next = use_r_reg;
        done_next  = 1'b0;
        case (state_reg)
            sts_pkg::ST_CLEAR:
            begin
                cp_next = cp_reg + AW'(1);
                if (cp_reg == AW'(DEPTH - 1))
                begin
                    state_next = sts_pkg::ST_IDLE;
                end
            end
            sts_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.is_query)
                    begin
                        acc_next = '0;
                        if (cmd.is_empty)
                        begin
                            state_next = sts_pkg::ST_Q_DONE;
                        end
                        else
                        begin
                            p_next     = PW'(cmd.lo) + PW'(LEAF_COUNT);
                            r_next     = PW'(cmd.hi) + PW'(LEAF_COUNT) + PW'(1);
                            state_next = sts_pkg::ST_Q_STEP;
                        end
                    end
                    else if (!cmd.is_empty)
                    begin
                        p_next     = PW'(cmd.lo) + PW'(LEAF_COUNT);
                        state_next = sts_pkg::ST_SET_LEAF;
                    end
                end
            end
            sts_pkg::ST_SET_LEAF:
            begin
                p_next     = p_reg >> 1;
                state_next = sts_pkg::ST_UP_READ_L;
            end
            sts_pkg::ST_UP_READ_L:
            begin
                state_next = sts_pkg::ST_UP_READ_R;
            end
            sts_pkg::ST_UP_READ_R:
            begin
                left_next  = rdata;
                state_next = sts_pkg::ST_UP_WAIT;
            end
            sts_pkg::ST_UP_WAIT:
            begin
                sum_next   = left_reg + rdata;
                state_next = sts_pkg::ST_UP_WRITE;
            end
            sts_pkg::ST_UP_WRITE:
            begin
                p_next = p_reg >> 1;
                if (p_reg == PW'(1))
                begin
                    state_next = sts_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = sts_pkg::ST_UP_READ_L;
                end
            end
            sts_pkg::ST_Q_STEP:
            begin
                // One level: take the odd left edge, then the odd right edge.
                if (p_reg >= r_reg)
                begin
                    state_next = sts_pkg::ST_Q_DONE;
                end
                else if (p_reg[0])
                begin
                    use_r_next = 1'b0;
                    pend_next  = r_reg[0];
                    state_next = sts_pkg::ST_Q_READ;
                end
                else if (r_reg[0])
                begin
                    r_next     = r_reg - PW'(1);
                    use_r_next = 1'b1;
                    pend_next  = 1'b0;
                    state_next = sts_pkg::ST_Q_READ;
                end
                else
                begin
                    p_next = p_reg >> 1;
                    r_next = r_reg >> 1;
                end
            end
            sts_pkg::ST_Q_READ:
            begin
                state_next = sts_pkg::ST_Q_ACC;
            end
            sts_pkg::ST_Q_ACC:
            begin
                acc_next = acc_reg + rdata;
                if (!use_r_reg)
                begin
                    p_next = p_reg + PW'(1);
                end
                if (pend_reg)
                begin
                    r_next     = r_reg - PW'(1);
                    use_r_next = 1'b1;
                    pend_next  = 1'b0;
                    state_next = sts_pkg::ST_Q_READ;
                end
                else
                begin
                    p_next     = (use_r_reg ? p_reg : p_reg + PW'(1)) >> 1;
                    r_next     = r_reg >> 1;
                    state_next = sts_pkg::ST_Q_STEP;
                end
            end
            sts_pkg::ST_Q_DONE:
            begin
                done_next  = 1'b1;
                state_next = sts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sts_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory port and handshake outputs.
    always_comb
    begin
        we    = 1'b0;
        addr  = p_reg[AW-1:0];
        wdata = sum_reg;
        pop   = 1'b0;
        case (state_reg)
            sts_pkg::ST_CLEAR:
            begin
                we    = 1'b1;
                addr  = cp_reg;
                wdata = '0;
            end
            sts_pkg::ST_IDLE:
            begin
                pop = cmd_valid;
            end
            sts_pkg::ST_SET_LEAF:
            begin
                we    = 1'b1;
                wdata = sum_reg;
            end
            sts_pkg::ST_UP_READ_L:
            begin
                addr = {p_reg[AW-2:0], 1'b0};
            end
            sts_pkg::ST_UP_READ_R:
            begin
                addr = {p_reg[AW-2:0], 1'b1};
            end
            sts_pkg::ST_UP_WRITE:
            begin
                we = 1'b1;
            end
            sts_pkg::ST_Q_READ:
            begin
                addr = use_r_reg ? r_reg[AW-1:0] : p_reg[AW-1:0];
            end
            default:
            begin
                addr = p_reg[AW-1:0];
            end
        endcase
    end

    assign clearing  = (state_reg == sts_pkg::ST_CLEAR);
    assign idle      = (state_reg == sts_pkg::ST_IDLE);
    assign done      = done_reg;
    assign range_sum = acc_reg;

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        r_reg     <= r_next;
        acc_reg   <= acc_next;
        left_reg  <= left_next;
        pend_reg  <= pend_next;
        use_r_reg <= use_r_next;
        if (state_reg == sts_pkg::ST_IDLE && cmd_valid)
        begin
            sum_reg <= cmd.value;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sts_pkg::ST_CLEAR;
            cp_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cp_reg    <= cp_next;
            done_reg  <= done_next;
        end
    end

endmodule
